// File: hdl/psc_pkg.sv
package psc_pkg;

  // Default parameter values for the top level
  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int MAX_DEGREE_DEF    = 6;
  localparam int FRACTION_BITS_DEF = 32;

  // Register port
  localparam int DEGREE_W    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int COEFF_W     = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_DEGREE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_BASE = 3'd1;

  // Horner accumulator: signed, clamped to +/- 2**CLAMP_EXP after each step.
  // A clamped value stays far outside the 64-bit range for the remaining
  // steps (each step moves it by less than 2**63), and a zero sample
  // restarts it exactly from the coefficient, so the final saturation
  // decision and sign are the same as with an exact accumulator.
  localparam int ACC_W     = 70;
  localparam int CLAMP_EXP = 67;
  localparam int LIMB_W    = 32;
  localparam int HI_W      = ACC_W - 2 * LIMB_W;

  localparam logic [COEFF_W-1:0] SAT_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic [COEFF_W-1:0] SAT_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

  typedef logic signed [COEFF_W-1:0] coeff_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// File: hdl/psc_cfg_regs.sv
module psc_cfg_regs
  import psc_pkg::*;
#(
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [COEFF_W-1:0]     wr_data,
  output coeff_t                 eff_coeff [MAX_DEGREE+1]
);

  logic [DEGREE_W-1:0] degree;
  coeff_t              coeff [MAX_DEGREE+1];
  logic [DEGREE_W-1:0] degree_eff;

  // Hold degree and coefficients; ignore writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_W'(1);
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        coeff[k] <= (k == 1) ? (COEFF_W'(1) << FRACTION_BITS) : '0;
      end
    end else if (wr_en) begin
      if (wr_index == REG_DEGREE) begin
        degree <= wr_data[DEGREE_W-1:0];
      end
      for (int k = 0; k <= MAX_DEGREE; k++) begin
        if (wr_index == REG_COEFF_BASE + CFG_INDEX_W'(k)) begin
          coeff[k] <= wr_data;
        end
      end
    end
  end

  // Limit degree to what the pipeline holds
  assign degree_eff = (degree > DEGREE_W'(MAX_DEGREE)) ? DEGREE_W'(MAX_DEGREE) : degree;

  // Zero coefficients above the degree
  always_comb begin
    for (int k = 0; k <= MAX_DEGREE; k++) begin
      eff_coeff[k] = (DEGREE_W'(k) <= degree_eff) ? coeff[k] : '0;
    end
  end

endmodule

// File: hdl/psc_horner_stage.sv
module psc_horner_stage
  import psc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_x,
  input  acc_t                   in_acc,
  input  coeff_t                 coeff,
  output logic                   out_valid,
  output logic [SAMPLE_BITS-1:0] out_x,
  output acc_t                   out_acc
);

  localparam int PW  = ACC_W + SAMPLE_BITS;
  localparam int LPW = LIMB_W + SAMPLE_BITS;
  localparam int HPW = HI_W + SAMPLE_BITS + 1;

  localparam logic signed [PW-1:0] LIM_HI = PW'(1) <<< CLAMP_EXP;
  localparam logic signed [PW-1:0] LIM_LO = -LIM_HI;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_x;
  logic [LPW-1:0]         s1_p0;
  logic [LPW-1:0]         s1_p1;
  logic signed [HPW-1:0]  s1_p2;

  logic [LPW-1:0]         p0;
  logic [LPW-1:0]         p1;
  logic signed [HPW-1:0]  p2;
  logic signed [PW-1:0]   sum;

  // Partial products of accumulator limbs by the sample
  assign p0 = in_acc[LIMB_W-1:0] * in_x;
  assign p1 = in_acc[2*LIMB_W-1:LIMB_W] * in_x;
  assign p2 = $signed(in_acc[ACC_W-1:2*LIMB_W]) * $signed({1'b0, in_x});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_x  <= in_x;
    s1_p0 <= p0;
    s1_p1 <= p1;
    s1_p2 <= p2;
  end

  // Combine partial products and add the coefficient
  assign sum = (PW'(s1_p2) <<< (2 * LIMB_W)) + (PW'(s1_p1) << LIMB_W)
             + PW'(s1_p0) + PW'(coeff);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  // Clamp far out-of-range values to keep the accumulator narrow
  always_ff @(posedge clk) begin
    out_x <= s1_x;
    if (sum > LIM_HI) begin
      out_acc <= ACC_W'(LIM_HI);
    end else if (sum < LIM_LO) begin
      out_acc <= ACC_W'(LIM_LO);
    end else begin
      out_acc <= ACC_W'(sum);
    end
  end

endmodule

// File: hdl/psc_saturate.sv
module psc_saturate
  import psc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  acc_t               in_acc,
  output logic               done,
  output logic [COEFF_W-1:0] calibrated,
  output logic               saturated
);

  logic fits;

  // Value fits when all bits from the 64-bit sign up are equal
  assign fits = (&in_acc[ACC_W-1:COEFF_W-1]) | ~(|in_acc[ACC_W-1:COEFF_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  // Clip to the signed 64-bit range and flag it
  always_ff @(posedge clk) begin
    if (fits) begin
      calibrated <= in_acc[COEFF_W-1:0];
      saturated  <= 1'b0;
    end else begin
      calibrated <= in_acc[ACC_W-1] ? SAT_MIN : SAT_MAX;
      saturated  <= 1'b1;
    end
  end

endmodule

// File: hdl/polynomial_sensor_calibration.sv
// Polynomial sensor calibration: calibrated = sum of coeff_i * sample**i,
// i = 0..degree, signed Q32.32, evaluated by Horner's rule and clipped
// to signed 64 bits with the saturated flag set when clipping happens.
// Input: drive sample and raise start; the transaction is taken at the
// clock edge where start is high and busy is low. busy is low except
// while rst is held, so a new sample can enter every cycle.
// Output: done pulses for one cycle with calibrated and saturated; the
// receiver cannot stall and must take the result in that cycle.
// Pipeline: one input register, two stages per Horner step (partial
// products, then add and clamp) and one saturation register.
// Throughput: one transaction per cycle, set by the fully pipelined
// chain of Horner steps.
// Configuration: write degree (index 0) and coeff_0..coeff_6 (index 1..7)
// through wr_en/wr_index/wr_data only while no transaction is in flight.
// Reset: rst (synchronous) empties the pipeline and restores degree 1,
// coeff_1 = 1.0 and all other coefficients 0.
module polynomial_sensor_calibration
  import psc_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int MAX_DEGREE    = MAX_DEGREE_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [COEFF_W-1:0]     wr_data,
  output logic                   done,
  output logic [COEFF_W-1:0]     calibrated,
  output logic                   saturated
);

  localparam int LATENCY = 2 * MAX_DEGREE + 2;

  coeff_t                 eff_coeff [MAX_DEGREE+1];
  logic                   chain_valid [MAX_DEGREE+1];
  logic [SAMPLE_BITS-1:0] chain_x   [MAX_DEGREE+1];
  acc_t                   chain_acc [MAX_DEGREE+1];

  // Accept nothing while reset is held
  assign busy = rst;

  psc_cfg_regs #(
    .MAX_DEGREE    (MAX_DEGREE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .eff_coeff (eff_coeff)
  );

  // Load the sample and seed the accumulator with the top coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else begin
      chain_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    chain_x[0]   <= sample;
    chain_acc[0] <= ACC_W'(eff_coeff[MAX_DEGREE]);
  end

  // One pipelined Horner step per remaining coefficient
  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
    psc_horner_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_x      (chain_x[k]),
      .in_acc    (chain_acc[k]),
      .coeff     (eff_coeff[MAX_DEGREE-1-k]),
      .out_valid (chain_valid[k+1]),
      .out_x     (chain_x[k+1]),
      .out_acc   (chain_acc[k+1])
    );
  end

  psc_saturate u_sat (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[MAX_DEGREE]),
    .in_acc     (chain_acc[MAX_DEGREE]),
    .done       (done),
    .calibrated (calibrated),
    .saturated  (saturated)
  );

`ifndef SYNTHESIS
  // Every accepted transaction produces a result
  a_latency_fwd : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction did not complete on time");

  // No result without a transaction accepted at the matching edge
  a_latency_back : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching transaction");

  // A clipped result sits at one of the range limits
  a_sat_value : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (calibrated == SAT_MAX || calibrated == SAT_MIN))
    else $error("saturated result not at a range limit");
`endif

endmodule
